// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: rtl/mi3_pkg.sv
// Shared constants and types of the 3x3 matrix inverse.
package mi3_pkg;
  localparam int IN_FRAC  = 12;
  localparam int OUT_FRAC = 16;
  localparam int SHIFT    = IN_FRAC + OUT_FRAC;
  localparam int AW       = 16;            // input element
  localparam int PW       = 2 * AW;        // 2x2 product
  localparam int CW       = 32;            // cofactor
  localparam int DPW      = AW + CW;       // element times cofactor
  localparam int DW       = DPW + 1;       // determinant
  localparam int QW       = 32;            // output element
  localparam int NW       = CW + SHIFT;    // scaled dividend
  localparam int NEL      = 9;

  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [QW-1:0] val;
    logic          sat;
    logic          zero;
  } res_t;
endpackage

// File: rtl/mi3_cof.sv
// Cofactor and determinant pipeline (five register stages).
module mi3_cof (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  input  logic signed [mi3_pkg::AW-1:0]    a_i   [mi3_pkg::NEL],
  output logic                             vld_o,
  output logic signed [mi3_pkg::CW-1:0]    adj_o [mi3_pkg::NEL],
  output logic signed [mi3_pkg::DW-1:0]    det_o
);
  // adj[k] = a[PI]*a[PJ] - a[NI]*a[NJ], sign of the cofactor folded in
  localparam int PI [mi3_pkg::NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PJ [mi3_pkg::NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int NI [mi3_pkg::NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int NJ [mi3_pkg::NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [4:0] vld_q;
  logic signed [mi3_pkg::AW-1:0]  a_q   [mi3_pkg::NEL];
  logic signed [mi3_pkg::PW-1:0]  pp_q  [mi3_pkg::NEL];
  logic signed [mi3_pkg::PW-1:0]  pn_q  [mi3_pkg::NEL];
  logic signed [mi3_pkg::AW-1:0]  r2_q  [3];
  logic signed [mi3_pkg::AW-1:0]  r3_q  [3];
  logic signed [mi3_pkg::CW-1:0]  adj3_q [mi3_pkg::NEL];
  logic signed [mi3_pkg::CW-1:0]  adj4_q [mi3_pkg::NEL];
  logic signed [mi3_pkg::CW-1:0]  adj5_q [mi3_pkg::NEL];
  logic signed [mi3_pkg::DPW-1:0] dp_q  [3];
  logic signed [mi3_pkg::DW-1:0]  det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_i;
    for (int k = 0; k < mi3_pkg::NEL; k++) begin
      pp_q[k]   <= mi3_pkg::PW'(a_q[PI[k]] * a_q[PJ[k]]);
      pn_q[k]   <= mi3_pkg::PW'(a_q[NI[k]] * a_q[NJ[k]]);
      adj3_q[k] <= mi3_pkg::CW'(pp_q[k] - pn_q[k]);
    end
    for (int j = 0; j < 3; j++) begin
      r2_q[j] <= a_q[j];
      r3_q[j] <= r2_q[j];
      dp_q[j] <= mi3_pkg::DPW'(r3_q[j] * adj3_q[3*j]);
    end
    adj4_q <= adj3_q;
    adj5_q <= adj4_q;
    det_q  <= mi3_pkg::DW'(dp_q[0]) + mi3_pkg::DW'(dp_q[1]) + mi3_pkg::DW'(dp_q[2]);
  end

  assign vld_o = vld_q[4];
  assign adj_o = adj5_q;
  assign det_o = det_q;
endmodule

// File: rtl/mi3_div.sv
// One lane: signed scaled division cofactor*2^SHIFT/det, one quotient bit per stage.
`include "assert_macros.svh"
module mi3_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic signed [mi3_pkg::CW-1:0] cof_i,
  input  logic signed [mi3_pkg::DW-1:0] det_i,
  output logic                          vld_o,
  output mi3_pkg::res_t                 res_o
);
  localparam int QW = mi3_pkg::QW;
  localparam int DW = mi3_pkg::DW;
  localparam int CW = mi3_pkg::CW;
  localparam int NW = mi3_pkg::NW;

  // prep stage
  logic          v0_q, neg0_q, zero0_q;
  logic [CW-1:0] cm0_q;
  logic [DW-1:0] dm0_q;

  // division stages, index 0 is the stage that loads the remainder
  logic          v_q    [QW+1];
  logic          neg_q  [QW+1];
  logic          zero_q [QW+1];
  logic          big_q  [QW+1];
  logic [DW-1:0] dm_q   [QW+1];
  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] nlo_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];

  logic          vo_q;
  mi3_pkg::res_t res_q;

  logic [NW-1:0] num;
  logic [DW-1:0] rem0;
  assign num  = {cm0_q, {mi3_pkg::SHIFT{1'b0}}};
  assign rem0 = DW'(num[NW-1:QW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v_q  <= '{default: 1'b0};
      vo_q <= 1'b0;
    end else begin
      v0_q <= vld_i;
      v_q[0] <= v0_q;
      for (int s = 0; s < QW; s++) begin
        v_q[s+1] <= v_q[s];
      end
      vo_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    neg0_q  <= cof_i[CW-1] ^ det_i[DW-1];
    zero0_q <= (det_i == '0);
    cm0_q   <= cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
    dm0_q   <= det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

    // quotient beyond QW bits is caught here
    neg_q[0]  <= neg0_q;
    zero_q[0] <= zero0_q;
    dm_q[0]   <= dm0_q;
    big_q[0]  <= (rem0 >= dm0_q);
    rem_q[0]  <= rem0;
    nlo_q[0]  <= num[QW-1:0];
    quo_q[0]  <= '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    always_comb begin
      trial = {rem_q[s], nlo_q[s][QW-1]};
      ge    = (trial >= {1'b0, dm_q[s]});
      diff  = trial - {1'b0, dm_q[s]};
    end
    always_ff @(posedge clk_i) begin
      neg_q[s+1]  <= neg_q[s];
      zero_q[s+1] <= zero_q[s];
      big_q[s+1]  <= big_q[s];
      dm_q[s+1]   <= dm_q[s];
      rem_q[s+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nlo_q[s+1]  <= {nlo_q[s][QW-2:0], 1'b0};
      quo_q[s+1]  <= {quo_q[s][QW-2:0], ge};
    end
  end

  logic [QW-1:0] lim, mag;
  logic          big;
  mi3_pkg::res_t res_d;
  always_comb begin
    lim = neg_q[QW] ? mi3_pkg::NEG_LIM : mi3_pkg::POS_LIM;
    big = big_q[QW] || (quo_q[QW] > lim);
    mag = big ? lim : quo_q[QW];
    res_d.val  = neg_q[QW] ? QW'(-mag) : mag;
    res_d.sat  = big;
    res_d.zero = zero_q[QW];
    if (zero_q[QW]) begin
      res_d.val = '0;
      res_d.sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = vo_q;
  assign res_o = res_q;

  `ASSERT_IMP(a_sat_at_limit, clk_i, rst_ni,
    vo_q && res_q.sat |-> (res_q.val == mi3_pkg::POS_LIM || res_q.val == mi3_pkg::NEG_LIM))
  `ASSERT_NEVER(a_zero_no_sat, clk_i, rst_ni, vo_q && res_q.zero && res_q.sat)
endmodule

// File: rtl/matrix_inverse_3x3.sv
// Top level of the 3x3 matrix inverse (adjugate over determinant).
// Usage:
//   Drive a00_i..a22_i (signed Q3.12) and pulse start; a beat is taken at
//   each rising edge with start high and busy low. busy stays low, so a
//   new matrix may be issued in every cycle.
//   For each accepted matrix, done_o is high for one cycle with
//   inv00_o..inv22_o (signed Q15.16, saturated), singular_o and overflow_o.
//   Throughput is one matrix per cycle. The result passes through
//   41 register stages, the first loaded at the accepting edge:
//   five stages for cofactors and determinant, then in each of the nine
//   division lanes a prep stage, a load stage, 32 stages of one quotient
//   bit each and a saturation stage; then the output register.
//   A zero determinant gives zero elements with singular_o set.
//   Reset (rst_ni low, asynchronous) drops every beat in flight.
//   The receiver has no back-pressure: results must be taken as they come.
`include "assert_macros.svh"
module matrix_inverse_3x3 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mi3_pkg::AW-1:0]       a00_i,
  input  logic signed [mi3_pkg::AW-1:0]       a01_i,
  input  logic signed [mi3_pkg::AW-1:0]       a02_i,
  input  logic signed [mi3_pkg::AW-1:0]       a10_i,
  input  logic signed [mi3_pkg::AW-1:0]       a11_i,
  input  logic signed [mi3_pkg::AW-1:0]       a12_i,
  input  logic signed [mi3_pkg::AW-1:0]       a20_i,
  input  logic signed [mi3_pkg::AW-1:0]       a21_i,
  input  logic signed [mi3_pkg::AW-1:0]       a22_i,
  output logic                                done_o,
  output logic signed [mi3_pkg::QW-1:0]       inv00_o,
  output logic signed [mi3_pkg::QW-1:0]       inv01_o,
  output logic signed [mi3_pkg::QW-1:0]       inv02_o,
  output logic signed [mi3_pkg::QW-1:0]       inv10_o,
  output logic signed [mi3_pkg::QW-1:0]       inv11_o,
  output logic signed [mi3_pkg::QW-1:0]       inv12_o,
  output logic signed [mi3_pkg::QW-1:0]       inv20_o,
  output logic signed [mi3_pkg::QW-1:0]       inv21_o,
  output logic signed [mi3_pkg::QW-1:0]       inv22_o,
  output logic                                singular_o,
  output logic                                overflow_o
);
  logic signed [mi3_pkg::AW-1:0] a [mi3_pkg::NEL];
  logic signed [mi3_pkg::CW-1:0] adj [mi3_pkg::NEL];
  logic signed [mi3_pkg::DW-1:0] det;
  logic                          cof_vld;
  logic [mi3_pkg::NEL-1:0]       lane_vld;
  mi3_pkg::res_t                 res [mi3_pkg::NEL];

  logic                          done_q;
  logic                          sing_q, ovf_q;
  logic [mi3_pkg::QW-1:0]        inv_q [mi3_pkg::NEL];
  logic [mi3_pkg::NEL-1:0]       sat_vec;

  assign busy = 1'b0;
  assign a = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  mi3_cof u_cof (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start & ~busy),
    .a_i    (a),
    .vld_o  (cof_vld),
    .adj_o  (adj),
    .det_o  (det)
  );

  for (genvar k = 0; k < mi3_pkg::NEL; k++) begin : g_lane
    mi3_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (cof_vld),
      .cof_i  (adj[k]),
      .det_i  (det),
      .vld_o  (lane_vld[k]),
      .res_o  (res[k])
    );
    assign sat_vec[k] = res[k].sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lane_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < mi3_pkg::NEL; k++) begin
      inv_q[k] <= res[k].val;
    end
    sing_q <= res[0].zero;
    ovf_q  <= |sat_vec;
  end

  assign done_o     = done_q;
  assign inv00_o    = inv_q[0];
  assign inv01_o    = inv_q[1];
  assign inv02_o    = inv_q[2];
  assign inv10_o    = inv_q[3];
  assign inv11_o    = inv_q[4];
  assign inv12_o    = inv_q[5];
  assign inv20_o    = inv_q[6];
  assign inv21_o    = inv_q[7];
  assign inv22_o    = inv_q[8];
  assign singular_o = sing_q;
  assign overflow_o = ovf_q;

  `ASSERT_IMP(a_singular_zero, clk_i, rst_ni,
    done_q && sing_q |-> !ovf_q && inv_q[0] == '0 && inv_q[4] == '0 && inv_q[8] == '0)
endmodule
